// ===== sv/catmull_rom_spline_eval_assert.svh =====
// Assertion macros shared by the spline evaluator checker.
`ifndef CATMULL_ROM_SPLINE_EVAL_ASSERT_SVH
`define CATMULL_ROM_SPLINE_EVAL_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define CRS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spline evaluator check failed");

// Next-cycle implication, off while reset is high.
`define CRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spline evaluator check failed");

`endif

// ===== sv/crs_pkg.sv =====
// Shared types and constants of the Catmull-Rom spline evaluator.
`timescale 1ns / 1ps
`default_nettype none

package crs_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed field widths
  localparam int COORD_W = 32;
  localparam int SLOT_W  = 6;
  localparam int T_W     = 17;
  localparam int CNT_W   = 7;

  // Working width of the Horner datapath: the largest value is below 24 * 2^31
  localparam int V_W = 37;

  // Word kinds carried in tuser
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  // Configuration register indexes
  localparam logic [0:0] REG_POINT_COUNT = 1'b0;
  localparam logic [0:0] REG_WRAP_MODE   = 1'b1;

  // One stored control point, x in the low bits
  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  // Load enables of the arithmetic pipeline stages
  typedef struct packed {
    logic coef;
    logic mul1;
    logic add1;
    logic mul2;
    logic add2;
    logic mul3;
    logic add3;
    logic outp;
  } stage_en_t;

endpackage

`default_nettype wire

// ===== sv/catmull_rom_spline_eval.sv =====
// Top level of the Catmull-Rom spline evaluator: point memory, read sequencer, pipeline control.
//
// Control points sit in a single-port synchronous memory of MAX_POINTS entries of
// 96 bits. A load word (tuser = 0) writes one point if its slot is below MAX_POINTS;
// loads can arrive every cycle while no evaluation holds the port. An evaluate word
// (tuser = 1) reads its four points from that memory, one read per cycle while read
// data is not waiting for the gather register, and a new word is taken only as its
// last read issues; the single memory port sets that limit. Behind the reads, a
// gather register and an eight-stage pipeline (coefficients, three multiply/round
// steps, halve and saturate) run the three axes side by side. A new word is taken
// while earlier results are still in the pipeline or waiting at the output.
// The memory has no reset: reading a point that was never loaded gives undefined
// coordinates. Configuration words are to be written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module catmull_rom_spline_eval #(
  parameter int MAX_POINTS = crs_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = crs_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // point_slot[5:0], coord_x[37:6], coord_y[69:38], coord_z[101:70],
  // segment_index[107:102], t_frac[124:108], zero[127:125]
  input  logic [127:0] s_tdata,
  // func[0]
  input  logic         s_tuser,
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64]
  output logic [95:0]  m_tdata,
  // configuration
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [6:0]   cfg_data
);

  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = crs_pkg::CNT_W;
  localparam int T_W    = crs_pkg::T_W;
  localparam logic [31:0] T_ONE = 32'd1 << FRAC_BITS;
  localparam int NSTG = 8;

  // Clamp a read address to the last point in use
  function automatic logic [CNT_W-1:0] clamp_addr(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] top);
    return (a > top) ? top : a;
  endfunction

  // Configuration registers
  logic [CNT_W-1:0] point_count;
  logic             wrap_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      wrap_mode   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        crs_pkg::REG_POINT_COUNT: point_count <= cfg_data;
        crs_pkg::REG_WRAP_MODE:   wrap_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input word fields
  logic [crs_pkg::SLOT_W-1:0]         in_slot;
  logic signed [crs_pkg::COORD_W-1:0] in_x, in_y, in_z;
  logic [crs_pkg::SLOT_W-1:0]         in_seg;
  logic [T_W-1:0]                     in_t;

  assign in_slot = s_tdata[5:0];
  assign in_x    = s_tdata[37:6];
  assign in_y    = s_tdata[69:38];
  assign in_z    = s_tdata[101:70];
  assign in_seg  = s_tdata[107:102];
  assign in_t    = s_tdata[124:108];

  // Address selection for an evaluate word
  logic [CNT_W-1:0] n_use, lim, top_a, seg7;
  logic             past_end;
  logic [CNT_W-1:0] acc_addr [4];
  logic [T_W-1:0]   t_clamped;

  always_comb begin
    n_use = (32'(point_count) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : point_count;
    lim   = (n_use >= CNT_W'(3)) ? n_use - CNT_W'(3) : '0;
    top_a = (n_use != '0) ? n_use - CNT_W'(1) : '0;
    seg7  = CNT_W'(in_seg);
    past_end = seg7 > lim;
    t_clamped = (32'(in_t) > T_ONE) ? T_W'(T_ONE) : in_t;
    if (seg7 == '0) begin
      for (int k = 0; k < 4; k++) acc_addr[k] = clamp_addr(CNT_W'(1), top_a);
    end else if (past_end && !wrap_mode) begin
      for (int k = 0; k < 4; k++) acc_addr[k] = clamp_addr(lim, top_a);
    end else begin
      acc_addr[0] = clamp_addr(seg7 - CNT_W'(1), top_a);
      acc_addr[1] = clamp_addr(seg7, top_a);
      if (past_end) begin
        acc_addr[2] = clamp_addr(CNT_W'(1), top_a);
        acc_addr[3] = clamp_addr(CNT_W'(2), top_a);
      end else begin
        acc_addr[2] = clamp_addr(seg7 + CNT_W'(1), top_a);
        acc_addr[3] = clamp_addr(seg7 + CNT_W'(2), top_a);
      end
    end
  end

  // Sequencer: holds one word, writes a load or issues four reads
  logic                busy;
  logic [1:0]          cnt;
  logic                sq_func;
  logic [CNT_W-1:0]    sq_addr [4];
  logic [T_W-1:0]      sq_t;
  logic                sq_slot_ok;
  logic [ADDR_W-1:0]   sq_waddr;
  crs_pkg::point_t     sq_wdata;

  logic s_acc, seq_load, rd_issue, seq_done, g_free;

  // Read return: mem_rdata holds a point until it reaches the gather register
  logic       rd_valid;
  logic [1:0] rd_slot;
  logic       g_wr;

  assign s_acc    = s_tvalid && s_tready;
  assign seq_load = busy && (sq_func == crs_pkg::FUNC_LOAD);
  assign rd_issue = busy && (sq_func == crs_pkg::FUNC_EVAL) && (!rd_valid || g_wr);
  assign seq_done = seq_load || (rd_issue && (cnt == 2'd3));
  assign s_tready = !busy || seq_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (s_acc) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (seq_done) begin
      busy <= 1'b0;
    end else if (rd_issue) begin
      cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      sq_func      <= s_tuser;
      sq_addr      <= acc_addr;
      sq_t         <= t_clamped;
      sq_slot_ok   <= 32'(in_slot) < MAX_POINTS;
      sq_waddr     <= ADDR_W'(in_slot);
      sq_wdata.x   <= in_x;
      sq_wdata.y   <= in_y;
      sq_wdata.z   <= in_z;
    end
  end

  // Point memory, single port, registered read
  crs_pkg::point_t   mem [MAX_POINTS];
  crs_pkg::point_t   mem_rdata;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;

  assign mem_we   = seq_load && sq_slot_ok;
  assign mem_addr = seq_load ? sq_waddr : ADDR_W'(sq_addr[cnt]);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= sq_wdata;
    end else if (rd_issue) begin
      mem_rdata <= mem[mem_addr];
    end
  end

  // Read data waits while the first point of a new evaluation finds the gather full
  assign g_wr = rd_valid && ((rd_slot != 2'd0) || g_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (rd_issue) begin
      rd_valid <= 1'b1;
    end else if (g_wr) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) rd_slot <= cnt;
  end

  // Gather register: the four points and t of one evaluation
  crs_pkg::point_t g_pt [4];
  logic [T_W-1:0]  g_t;
  logic            gv, g_move;
  logic [NSTG+1:1] rdy;
  logic [NSTG:1]   vld, vin, ld;

  assign g_move = gv && rdy[1];
  assign g_free = !gv || g_move;

  always_ff @(posedge clk) begin
    if (g_wr) g_pt[rd_slot] <= mem_rdata;
    if (g_wr && (rd_slot == 2'd0)) g_t <= sq_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gv <= 1'b0;
    end else if (g_wr && (rd_slot == 2'd3)) begin
      gv <= 1'b1;
    end else if (g_move) begin
      gv <= 1'b0;
    end
  end

  // Pipeline flow control: a stage loads when empty or when it moves on
  always_comb begin
    rdy[NSTG+1] = m_tready;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
    vin[1] = gv;
    for (int k = 2; k <= NSTG; k++) begin
      vin[k] = vld[k-1];
    end
    for (int k = 1; k <= NSTG; k++) begin
      ld[k] = rdy[k] && vin[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (rdy[k]) vld[k] <= vin[k];
      end
    end
  end

  crs_pkg::stage_en_t stage_en;

  assign stage_en.coef = ld[1];
  assign stage_en.mul1 = ld[2];
  assign stage_en.add1 = ld[3];
  assign stage_en.mul2 = ld[4];
  assign stage_en.add2 = ld[5];
  assign stage_en.mul3 = ld[6];
  assign stage_en.add3 = ld[7];
  assign stage_en.outp = ld[8];

  // t travels alongside the first five stages
  logic [T_W-1:0] t_pipe [1:5];

  always_ff @(posedge clk) begin
    if (ld[1]) t_pipe[1] <= g_t;
    for (int k = 2; k <= 5; k++) begin
      if (ld[k]) t_pipe[k] <= t_pipe[k-1];
    end
  end

  // Three axes in parallel
  logic signed [crs_pkg::COORD_W-1:0] pos_x, pos_y, pos_z;

  crs_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk (clk), .en (stage_en),
    .p0 (g_pt[0].x), .p1 (g_pt[1].x), .p2 (g_pt[2].x), .p3 (g_pt[3].x),
    .t_m1 (t_pipe[1]), .t_m2 (t_pipe[3]), .t_m3 (t_pipe[5]),
    .pos (pos_x)
  );

  crs_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk (clk), .en (stage_en),
    .p0 (g_pt[0].y), .p1 (g_pt[1].y), .p2 (g_pt[2].y), .p3 (g_pt[3].y),
    .t_m1 (t_pipe[1]), .t_m2 (t_pipe[3]), .t_m3 (t_pipe[5]),
    .pos (pos_y)
  );

  crs_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_z (
    .clk (clk), .en (stage_en),
    .p0 (g_pt[0].z), .p1 (g_pt[1].z), .p2 (g_pt[2].z), .p3 (g_pt[3].z),
    .t_m1 (t_pipe[1]), .t_m2 (t_pipe[3]), .t_m3 (t_pipe[5]),
    .pos (pos_z)
  );

  // Output word
  assign m_tvalid = vld[NSTG];
  assign m_tdata  = {pos_z, pos_y, pos_x};

endmodule

`default_nettype wire

// ===== sv/crs_axis.sv =====
// One coordinate axis of the spline arithmetic: coefficients, Horner steps, rounding.
`timescale 1ns / 1ps
`default_nettype none

module crs_axis #(
  parameter int FRAC_BITS = crs_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  crs_pkg::stage_en_t                   en,
  input  logic signed [crs_pkg::COORD_W-1:0]   p0,
  input  logic signed [crs_pkg::COORD_W-1:0]   p1,
  input  logic signed [crs_pkg::COORD_W-1:0]   p2,
  input  logic signed [crs_pkg::COORD_W-1:0]   p3,
  input  logic        [crs_pkg::T_W-1:0]       t_m1,
  input  logic        [crs_pkg::T_W-1:0]       t_m2,
  input  logic        [crs_pkg::T_W-1:0]       t_m3,
  output logic signed [crs_pkg::COORD_W-1:0]   pos
);

  localparam int V_W = crs_pkg::V_W;
  localparam int P_W = V_W + crs_pkg::T_W + 1;
  localparam logic signed [P_W-1:0] HALF = P_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [V_W-1:0] SAT_HI = V_W'(signed'(32'h7FFF_FFFF));
  localparam logic signed [V_W-1:0] SAT_LO = V_W'(signed'(32'h8000_0000));

  // k + round-half-up(prod / 2^FRAC_BITS)
  function automatic logic signed [V_W-1:0] rnd_add(input logic signed [V_W-1:0] k,
                                                    input logic signed [P_W-1:0] prod);
    logic signed [P_W-1:0] sh;
    sh = (prod + HALF) >>> FRAC_BITS;
    return k + V_W'(sh);
  endfunction

  logic signed [V_W-1:0] ex0, ex1, ex2, ex3;
  logic signed [V_W-1:0] co_a, co_b, co_c, co_d;
  logic signed [P_W-1:0] prod2, prod4, prod6;
  logic signed [V_W-1:0] a2, b2, c2;
  logic signed [V_W-1:0] v3, a3, b3;
  logic signed [V_W-1:0] a4, b4;
  logic signed [V_W-1:0] v5, a5;
  logic signed [V_W-1:0] a6;
  logic signed [V_W-1:0] v7;
  logic signed [V_W-1:0] halved;

  assign ex0 = V_W'(p0);
  assign ex1 = V_W'(p1);
  assign ex2 = V_W'(p2);
  assign ex3 = V_W'(p3);

  // Coefficients, exact
  always_ff @(posedge clk) begin
    if (en.coef) begin
      co_a <= ex1 <<< 1;
      co_b <= ex2 - ex0;
      co_c <= (ex0 <<< 1) - ((ex1 <<< 2) + ex1) + (ex2 <<< 2) - ex3;
      co_d <= (ex1 + (ex1 <<< 1)) - (ex2 + (ex2 <<< 1)) + ex3 - ex0;
    end
  end

  // Horner step 1: d * t, then c + round
  always_ff @(posedge clk) begin
    if (en.mul1) begin
      prod2 <= P_W'(co_d) * P_W'($signed({1'b0, t_m1}));
      a2    <= co_a;
      b2    <= co_b;
      c2    <= co_c;
    end
    if (en.add1) begin
      v3 <= rnd_add(c2, prod2);
      a3 <= a2;
      b3 <= b2;
    end
  end

  // Horner step 2: v * t, then b + round
  always_ff @(posedge clk) begin
    if (en.mul2) begin
      prod4 <= P_W'(v3) * P_W'($signed({1'b0, t_m2}));
      a4    <= a3;
      b4    <= b3;
    end
    if (en.add2) begin
      v5 <= rnd_add(b4, prod4);
      a5 <= a4;
    end
  end

  // Horner step 3: v * t, then a + round
  always_ff @(posedge clk) begin
    if (en.mul3) begin
      prod6 <= P_W'(v5) * P_W'($signed({1'b0, t_m3}));
      a6    <= a5;
    end
    if (en.add3) begin
      v7 <= rnd_add(a6, prod6);
    end
  end

  // Halve with rounding half up, then saturate to 32 bits
  assign halved = (v7 + V_W'(1)) >>> 1;

  always_ff @(posedge clk) begin
    if (en.outp) begin
      if (halved > SAT_HI) begin
        pos <= SAT_HI[crs_pkg::COORD_W-1:0];
      end else if (halved < SAT_LO) begin
        pos <= SAT_LO[crs_pkg::COORD_W-1:0];
      end else begin
        pos <= halved[crs_pkg::COORD_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/crs_checker.sv =====
// Port-level checker for the spline evaluator, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

`include "catmull_rom_spline_eval_assert.svh"

module crs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [95:0] m_tdata,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  // A stalled result word holds
  `CRS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // An evaluate word keeps the single memory port for its four reads
  `CRS_ASSERT_NEXT(a_eval_port, clk, rst, s_tvalid && s_tready && s_tuser == crs_pkg::FUNC_EVAL, !s_tready ##1 !s_tready ##1 !s_tready)

  // After a load word is taken, the input is ready again in the next cycle
  `CRS_ASSERT_NEXT(a_load_turn, clk, rst, s_tvalid && s_tready && s_tuser == crs_pkg::FUNC_LOAD, s_tready)

  // Configuration writes are never held off
  `CRS_ASSERT_SAME(a_cfg_open, clk, rst, cfg_valid, cfg_ready)

endmodule

bind catmull_rom_spline_eval crs_checker u_crs_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .s_tuser   (s_tuser),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
